/* rtl/timer_tick_rate_converter_macros.svh */
// Assertion macros for the tick rate converter.
`ifndef TIMER_TICK_RATE_CONVERTER_MACROS_SVH
`define TIMER_TICK_RATE_CONVERTER_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define TTRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define TTRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ttrc_pkg.sv */
// Shared constants for the tick rate converter.
`default_nettype none

package ttrc_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int ADDR_W    = 3;

    typedef enum logic [0:0] {
        REG_RATIO_MUL = 1'b0,
        REG_RATIO_DIV = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        KIND_SET = 1'b0,
        KIND_NOW = 1'b1
    } kind_t;

endpackage

`default_nettype wire

/* rtl/timer_tick_rate_converter.sv */
// Top level: pipelined rational tick rate converter (multiply, then restoring divide).
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  s_ (in)  | s_valid / s_ready  | s_kind, s_tick_value
//  m_ (out) | m_valid / m_ready  | m_converted_ticks
//  apb cfg  | psel/penable/pwrite| paddr, pwdata, prdata, pready
//
// DIV_STEPS + 3 = 67 register stages: multiply, ceiling adjust, the divider steps and the output register;
// one request may enter every cycle while the output is not stalled.
// The divider sets the stage count: one quotient bit per stage over the 64-bit product.
// Reset clears the valid bits and sets both ratio terms to 1; no clearing pass.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

`include "timer_tick_rate_converter_macros.svh"

module timer_tick_rate_converter
    import ttrc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // request input
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_kind,
    input  wire logic [DATA_W-1:0] s_tick_value,
    // result output
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_converted_ticks,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // ---------------- configuration ----------------
    logic [DATA_W-1:0] mul_reg, div_reg;
    logic [DATA_W-1:0] mul_eff, div_eff;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg <= DATA_W'(1);
            div_reg <= DATA_W'(1);
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_idx)
                REG_RATIO_MUL: mul_reg <= pwdata;
                REG_RATIO_DIV: div_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RATIO_MUL: prdata = mul_reg;
            REG_RATIO_DIV: prdata = div_reg;
            default:       prdata = '0;
        endcase
    end

    // a term of 0 behaves as 1 (skipped)
    assign mul_eff = (mul_reg == '0) ? DATA_W'(1) : mul_reg;
    assign div_eff = (div_reg == '0) ? DATA_W'(1) : div_reg;

    // ---------------- pipeline control ----------------
    logic adv;
    logic out_valid_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------- stage 1: multiply ----------------
    logic              p1_valid_reg;
    kind_t             p1_kind_reg;
    logic [PROD_W-1:0] p1_prod_reg;
    logic [PROD_W-1:0] p1_prod_next;
    logic [DATA_W-1:0] factor;

    assign factor       = (kind_t'(s_kind) == KIND_SET) ? mul_eff : div_eff;
    assign p1_prod_next = PROD_W'(s_tick_value) * PROD_W'(factor);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_kind_reg <= kind_t'(s_kind);
            p1_prod_reg <= p1_prod_next;
        end
    end

    // ---------------- stage 2: ceiling adjust ----------------
    // ceil(n/d) = 1 + (n-1)/d for n > 0; the +1 is added after the divider
    logic              p2_valid_reg;
    kind_t             p2_kind_reg;
    logic              p2_inc_reg;
    logic [PROD_W-1:0] p2_num_reg;
    logic              p2_inc_next;
    logic [PROD_W-1:0] p2_num_next;

    assign p2_inc_next = (p1_kind_reg == KIND_SET) && (p1_prod_reg != '0);
    assign p2_num_next = p2_inc_next ? (p1_prod_reg - PROD_W'(1)) : p1_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_kind_reg <= p1_kind_reg;
            p2_inc_reg  <= p2_inc_next;
            p2_num_reg  <= p2_num_next;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    // numerator shifts out at the top while quotient bits shift in at the bottom
    logic              dv_valid_reg [DIV_STEPS];
    kind_t             dv_kind_reg  [DIV_STEPS];
    logic              dv_inc_reg   [DIV_STEPS];
    logic [DATA_W-1:0] dv_rem_reg   [DIV_STEPS];
    logic [PROD_W-1:0] dv_num_reg   [DIV_STEPS];
    logic [DATA_W-1:0] dv_rem_next  [DIV_STEPS];
    logic [PROD_W-1:0] dv_num_next  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic              v_in;
        kind_t             kind_in;
        logic              inc_in;
        logic [DATA_W-1:0] rem_in;
        logic [PROD_W-1:0] num_in;
        logic [DATA_W-1:0] den;
        logic [DATA_W:0]   trial;
        logic              take;

        if (k == 0) begin : g_first
            assign v_in    = p2_valid_reg;
            assign kind_in = p2_kind_reg;
            assign inc_in  = p2_inc_reg;
            assign rem_in  = '0;
            assign num_in  = p2_num_reg;
        end else begin : g_rest
            assign v_in    = dv_valid_reg[k-1];
            assign kind_in = dv_kind_reg[k-1];
            assign inc_in  = dv_inc_reg[k-1];
            assign rem_in  = dv_rem_reg[k-1];
            assign num_in  = dv_num_reg[k-1];
        end

        assign den = (kind_in == KIND_SET) ? div_eff : mul_eff;

        always_comb begin
            trial          = {rem_in, num_in[PROD_W-1]};
            take           = (trial >= {1'b0, den});
            dv_rem_next[k] = take ? DATA_W'(trial - {1'b0, den}) : trial[DATA_W-1:0];
            dv_num_next[k] = {num_in[PROD_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_kind_reg[k] <= kind_in;
                dv_inc_reg[k]  <= inc_in;
                dv_rem_reg[k]  <= dv_rem_next[k];
                dv_num_reg[k]  <= dv_num_next[k];
            end
        end
    end

    // ---------------- output stage ----------------
    localparam int LAST = DIV_STEPS - 1;

    logic [DATA_W-1:0] out_reg;
    logic [DATA_W-1:0] out_next;
    logic [DATA_W-1:0] last_den;

    assign out_next = dv_num_reg[LAST][DATA_W-1:0] + DATA_W'(dv_inc_reg[LAST]);
    assign last_den = (dv_kind_reg[LAST] == KIND_SET) ? div_eff : mul_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_valid_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_converted_ticks = out_reg;

    // ---------------- assertions ----------------
    `TTRC_ASSERT_NEXT(a_last_to_out, dv_valid_reg[LAST] && adv, out_valid_reg, "result lost")
    `TTRC_ASSERT_NOW(a_rem_below_den, dv_valid_reg[LAST], dv_rem_reg[LAST] < last_den, "bad rem")
    `TTRC_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, s_ready, "input blocked")

endmodule

`default_nettype wire
